>>> hdl/bgc_pkg.sv
`default_nettype none
package bgc_pkg;

	localparam int unsigned TimeW  = 32;
	localparam int unsigned CfgW   = 16;
	localparam int unsigned CountW = 4;
	localparam int unsigned IdxW   = 3;

	localparam logic [CountW-1:0] ClickMax = 4'd15;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_SINGLE    = 3'd1,
		EV_MULTI     = 3'd2,
		EV_LONG      = 3'd3,
		EV_ARMED     = 3'd4,
		EV_CONFIRMED = 3'd5
	} bgc_event_t;

	typedef enum logic [IdxW-1:0] {
		REG_DEBOUNCE     = 3'd0,
		REG_DOUBLE_CLICK = 3'd1,
		REG_LONG_PRESS   = 3'd2,
		REG_FACTORY_HOLD = 3'd3,
		REG_RESET_WINDOW = 3'd4,
		REG_CLEAN_BOOT   = 3'd5
	} bgc_reg_t;

	typedef struct packed {
		logic             pressed;
		logic [TimeW-1:0] now_ms;
	} bgc_smp_t;

	typedef struct packed {
		logic [2:0]        event_res;
		logic [CountW-1:0] click_count;
		logic              reset_armed;
	} bgc_res_t;

	typedef struct packed {
		logic [IdxW-1:0] idx;
		logic [CfgW-1:0] wdata;
	} bgc_cfg_t;

endpackage
`default_nettype wire

>>> hdl/bgc_intf.sv
`default_nettype none
interface bgc_smp_if import bgc_pkg::*; ();
	logic     valid;
	logic     ready;
	bgc_smp_t data;
	modport src (output valid, output data, input ready);
	modport snk (input valid, input data, output ready);
endinterface

interface bgc_res_if import bgc_pkg::*; ();
	logic     valid;
	logic     ready;
	bgc_res_t data;
	modport src (output valid, output data, input ready);
	modport snk (input valid, input data, output ready);
endinterface

interface bgc_cfg_if import bgc_pkg::*; ();
	logic     valid;
	logic     ready;
	bgc_cfg_t data;
	modport src (output valid, output data, input ready);
	modport snk (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/button_gesture_classifier_unit.sv
`default_nettype none
// Button gesture classifier. Each sample item (pressed, now_ms) yields exactly one
// result item (event_res, click_count, reset_armed), in order. The block ignores the
// button after reset until it is first seen released, debounces presses against the
// last release time, reports long press or factory-reset armed on a held press, counts
// clicks on release (saturating at 15) and reports single/multi click once the
// double-click gap has passed; a release while armed reports reset confirmed and
// returns gesture state to its reset values, but the window reopens only when clean
// boot is set (registers keep their values). Timing: one sample item per cycle
// sustained while result ready stays high; a sample passes the input register, then
// one pass of compare/subtract logic into the result register. Sample ready depends
// combinationally on result ready. Registers are written through the cfg channel,
// which is always ready; write them only while no item is in flight.
module button_gesture_classifier_unit import bgc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bgc_smp_if.snk    smp,
	bgc_res_if.src    res,
	bgc_cfg_if.snk    cfg
);

	// configuration registers
	logic [CfgW-1:0] debounce_q, dclick_q, long_q, fhold_q, rwin_q;
	logic            clean_boot_q;

	// gesture state
	logic              ign_q, held_q, long_done_q, win_q, elig_q, armed_q;
	logic [TimeW-1:0]  press_time_q, rel_time_q;
	logic [CountW-1:0] pend_q;

	// pipeline
	logic     smp_vld_s1;
	bgc_smp_t smp_data_s1;
	logic     res_vld_s2;
	bgc_res_t res_data_s2;
	logic     adv;

	// next-state values
	logic              ign_d, held_d, long_done_d, win_d, elig_d, armed_d;
	logic [TimeW-1:0]  press_time_d, rel_time_d;
	logic [CountW-1:0] pend_d;
	bgc_event_t        ev_d;
	logic [CountW-1:0] cnt_d;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= 16'd50;
			dclick_q     <= 16'd400;
			long_q       <= 16'd3000;
			fhold_q      <= 16'd5000;
			rwin_q       <= 16'd20000;
			clean_boot_q <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.data.idx)
				REG_DEBOUNCE:     debounce_q   <= cfg.data.wdata;
				REG_DOUBLE_CLICK: dclick_q     <= cfg.data.wdata;
				REG_LONG_PRESS:   long_q       <= cfg.data.wdata;
				REG_FACTORY_HOLD: fhold_q      <= cfg.data.wdata;
				REG_RESET_WINDOW: rwin_q       <= cfg.data.wdata;
				REG_CLEAN_BOOT:   clean_boot_q <= cfg.data.wdata[0];
				default: ;
			endcase
		end
	end

	// stage 1 moves into the result register when that register is free or draining
	assign adv       = smp_vld_s1 && (!res_vld_s2 || res.ready);
	assign smp.ready = !smp_vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_vld_s1 <= 1'b0;
		end else if (smp.ready) begin
			smp_vld_s1 <= smp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (smp.ready && smp.valid) begin
			smp_data_s1 <= smp.data;
		end
	end

	// one step of the gesture logic
	always_comb begin
		logic             pr;
		logic [TimeW-1:0] now;
		logic [TimeW-1:0] held_for;
		logic             done;
		pr           = smp_data_s1.pressed;
		now          = smp_data_s1.now_ms;
		done         = 1'b0;
		ign_d        = ign_q;
		held_d       = held_q;
		long_done_d  = long_done_q;
		win_d        = win_q;
		elig_d       = elig_q;
		armed_d      = armed_q;
		press_time_d = press_time_q;
		rel_time_d   = rel_time_q;
		pend_d       = pend_q;
		ev_d         = EV_NONE;
		cnt_d        = '0;

		// window closing is checked on every step
		if (win_q && now >= {{(TimeW-CfgW){1'b0}}, rwin_q}) begin
			win_d = 1'b0;
		end

		// start-up: wait for the first release
		if (ign_q) begin
			if (!pr) begin
				ign_d = 1'b0;
			end
			done = 1'b0;
		end

		// new press, debounced against last release
		if (!ign_q && pr && !held_q) begin
			if ((now - rel_time_q) < {{(TimeW-CfgW){1'b0}}, debounce_q}) begin
				done = 1'b1;
			end else begin
				held_d       = 1'b1;
				press_time_d = now;
				long_done_d  = 1'b0;
				elig_d       = win_d;
			end
		end

		held_for = now - press_time_d;
		if (!ign_q && !done && held_d && pr && !long_done_d) begin
			if (elig_d && held_for >= {{(TimeW-CfgW){1'b0}}, fhold_q}) begin
				long_done_d = 1'b1;
				pend_d      = '0;
				armed_d     = 1'b1;
				ev_d        = EV_ARMED;
			end else if (!elig_d && held_for >= {{(TimeW-CfgW){1'b0}}, long_q}) begin
				long_done_d = 1'b1;
				pend_d      = '0;
				ev_d        = EV_LONG;
			end
		end

		// release: count a click or confirm factory reset
		if (!ign_q && !done && !pr && held_d) begin
			held_d     = 1'b0;
			rel_time_d = now;
			elig_d     = 1'b0;
			if (armed_d) begin
				ign_d        = 1'b1;
				held_d       = 1'b0;
				press_time_d = '0;
				rel_time_d   = '0;
				pend_d       = '0;
				long_done_d  = 1'b0;
				win_d        = clean_boot_q;
				elig_d       = 1'b0;
				armed_d      = 1'b0;
				ev_d         = EV_CONFIRMED;
				done         = 1'b1;
			end else if (!long_done_d && pend_d < ClickMax) begin
				pend_d = pend_d + 1'b1;
			end
		end

		// flush pending clicks once the double-click gap has closed
		if (!ign_q && !done && pend_d != '0 && !held_d &&
			(now - rel_time_d) >= {{(TimeW-CfgW){1'b0}}, dclick_q}) begin
			cnt_d  = pend_d;
			ev_d   = (pend_d == 4'd1) ? EV_SINGLE : EV_MULTI;
			pend_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ign_q        <= 1'b1;
			held_q       <= 1'b0;
			long_done_q  <= 1'b0;
			win_q        <= 1'b1;
			elig_q       <= 1'b0;
			armed_q      <= 1'b0;
			press_time_q <= '0;
			rel_time_q   <= '0;
			pend_q       <= '0;
		end else if (adv) begin
			ign_q        <= ign_d;
			held_q       <= held_d;
			long_done_q  <= long_done_d;
			win_q        <= win_d;
			elig_q       <= elig_d;
			armed_q      <= armed_d;
			press_time_q <= press_time_d;
			rel_time_q   <= rel_time_d;
			pend_q       <= pend_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s2 <= 1'b0;
		end else if (adv) begin
			res_vld_s2 <= 1'b1;
		end else if (res.ready) begin
			res_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_data_s2.event_res   <= ev_d;
			res_data_s2.click_count <= cnt_d;
			res_data_s2.reset_armed <= armed_d;
		end
	end

	assign res.valid = res_vld_s2;
	assign res.data  = res_data_s2;

	// armed only while a press is held past start-up
	a_armed_held: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> (held_q && !ign_q))
		else $error("armed without held press");

	// click count only rides with click events
	a_count_only_click: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.event_res != EV_SINGLE && res.data.event_res != EV_MULTI)
		|-> (res.data.click_count == '0))
		else $error("click count on non-click event");

	// single click carries exactly one click
	a_single_one: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.event_res == EV_SINGLE) |-> (res.data.click_count == 4'd1))
		else $error("single click count mismatch");

	// confirmation drops the armed flag and restarts in ignore mode
	a_confirm_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ev_d == EV_CONFIRMED) |=> (ign_q && !armed_q && res.data.reset_armed == 1'b0))
		else $error("reset confirm did not clear state");

endmodule
`default_nettype wire

>>> verif/bgc_gesture_checker.sv
`timescale 1ns / 100ps
module bgc_gesture_checker import bgc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        smp_valid,
	input  logic        smp_ready,
	input  bgc_smp_t    smp_data,
	input  logic        res_valid,
	input  logic        res_ready,
	input  bgc_res_t    res_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  bgc_cfg_t    cfg_data,
	output int unsigned reports_due,
	output int unsigned fail_count
);

	// register copies
	logic [CfgW-1:0] debounce_ms, dclick_gap, long_hold;
	logic [CfgW-1:0] factory_hold_ms, reset_window_ms;
	logic            clean_boot;

	// gesture state
	logic              ignore_rel, held, long_done, win_open, eligible, armed;
	logic [TimeW-1:0]  press_t, rel_t;
	logic [CountW-1:0] clicks;

	bgc_res_t    gesture_reports[$];
	int unsigned mismatches;

	assign fail_count = mismatches;

	task automatic clear_gesture_state();
		ignore_rel = 1'b1;
		held       = 1'b0;
		press_t    = '0;
		rel_t      = '0;
		clicks     = '0;
		long_done  = 1'b0;
		win_open   = clean_boot;
		eligible   = 1'b0;
		armed      = 1'b0;
	endtask

	// one sample in, one report predicted
	task automatic classify_sample(input logic pressed, input logic [TimeW-1:0] now);
		bgc_res_t         rep;
		bgc_event_t       ev;
		logic [CountW-1:0] cnt;
		logic [TimeW-1:0] dt;
		logic             done;
		ev   = EV_NONE;
		cnt  = '0;
		done = 1'b0;
		if (win_open && now >= {16'd0, reset_window_ms})
			win_open = 1'b0;
		if (ignore_rel) begin
			if (!pressed)
				ignore_rel = 1'b0;
			done = 1'b1;
		end else if (pressed && !held) begin
			dt = now - rel_t;
			if (dt < {16'd0, debounce_ms}) begin
				done = 1'b1;
			end else begin
				held      = 1'b1;
				press_t   = now;
				long_done = 1'b0;
				eligible  = win_open;
			end
		end
		if (!done && held && pressed && !long_done) begin
			dt = now - press_t;
			if (eligible && dt >= {16'd0, factory_hold_ms}) begin
				long_done = 1'b1;
				clicks    = '0;
				armed     = 1'b1;
				ev        = EV_ARMED;
			end else if (!eligible && dt >= {16'd0, long_hold}) begin
				long_done = 1'b1;
				clicks    = '0;
				ev        = EV_LONG;
			end
		end
		if (!done && !pressed && held) begin
			held     = 1'b0;
			rel_t    = now;
			eligible = 1'b0;
			if (armed) begin
				clear_gesture_state();
				ev   = EV_CONFIRMED;
				done = 1'b1;
			end else if (!long_done && clicks < ClickMax) begin
				clicks = clicks + 1'b1;
			end
		end
		if (!done && clicks != '0 && !held) begin
			dt = now - rel_t;
			if (dt >= {16'd0, dclick_gap}) begin
				cnt    = clicks;
				ev     = (cnt == 4'd1) ? EV_SINGLE : EV_MULTI;
				clicks = '0;
			end
		end
		rep.event_res   = ev;
		rep.click_count = cnt;
		rep.reset_armed = armed;
		gesture_reports.push_back(rep);
	endtask

	task automatic check_report(input bgc_res_t got);
		bgc_res_t want;
		if (gesture_reports.size() == 0) begin
			$error("result item with nothing predicted: event_res %0d click_count %0d",
				got.event_res, got.click_count);
			mismatches++;
		end else begin
			want = gesture_reports.pop_front();
			if (got.event_res !== want.event_res) begin
				$error("event_res mismatch: expected %0d, actual %0d",
					want.event_res, got.event_res);
				mismatches++;
			end
			if (got.click_count !== want.click_count) begin
				$error("click_count mismatch: expected %0d, actual %0d",
					want.click_count, got.click_count);
				mismatches++;
			end
			if (got.reset_armed !== want.reset_armed) begin
				$error("reset_armed mismatch: expected %0d, actual %0d",
					want.reset_armed, got.reset_armed);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms     = 16'd50;
			dclick_gap      = 16'd400;
			long_hold       = 16'd3000;
			factory_hold_ms = 16'd5000;
			reset_window_ms = 16'd20000;
			clean_boot      = 1'b1;
			clear_gesture_state();
			gesture_reports.delete();
			mismatches      = 0;
			reports_due    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.idx)
					REG_DEBOUNCE:     debounce_ms     = cfg_data.wdata;
					REG_DOUBLE_CLICK: dclick_gap      = cfg_data.wdata;
					REG_LONG_PRESS:   long_hold       = cfg_data.wdata;
					REG_FACTORY_HOLD: factory_hold_ms = cfg_data.wdata;
					REG_RESET_WINDOW: reset_window_ms = cfg_data.wdata;
					REG_CLEAN_BOOT:   clean_boot      = cfg_data.wdata[0];
					default: ;
				endcase
			end
			if (res_valid && res_ready)
				check_report(res_data);
			if (smp_valid && smp_ready)
				classify_sample(smp_data.pressed, smp_data.now_ms);
			reports_due <= gesture_reports.size();
		end
	end

endmodule

>>> verif/button_gesture_classifier_unit_tb.sv
`timescale 1ns / 100ps
module button_gesture_classifier_unit_tb;
	import bgc_pkg::*;

	localparam int unsigned HoldOffCycles = 64;    // long receiver stall
	localparam int unsigned WatchdogLimit = 2000;  // cycles with no handshake at all
	localparam int unsigned SettleCycles  = 4;     // margin after the final drain

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bgc_smp_if smp_ch ();
	bgc_res_if res_ch ();
	bgc_cfg_if cfg_ch ();

	int unsigned reports_due;
	int unsigned fail_count;

	button_gesture_classifier_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// watches all three channels, predicts every report and compares
	bgc_gesture_checker gesture_watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.smp_valid   (smp_ch.valid),
		.smp_ready   (smp_ch.ready),
		.smp_data    (smp_ch.data),
		.res_valid   (res_ch.valid),
		.res_ready   (res_ch.ready),
		.res_data    (res_ch.data),
		.cfg_valid   (cfg_ch.valid),
		.cfg_ready   (cfg_ch.ready),
		.cfg_data    (cfg_ch.data),
		.reports_due (reports_due),
		.fail_count  (fail_count)
	);

	always #10 clk = ~clk;

	// stimulus time base; moves forward per sample, jumps on noise and rewinds
	logic [31:0] clock_ms   = '0;
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	logic        gaps_on    = 1'b0;   // sender bursts with gaps between them
	int unsigned sink_mode  = 0;      // 0 always ready, 1 light stalls, 2 heavy stalls
	logic        hold_off_req = 1'b0; // one-shot request for a long receiver stall

	// register values as last written, used only to shape gesture timing
	logic [15:0] sh_debounce = 16'd50;
	logic [15:0] sh_double   = 16'd400;
	logic [15:0] sh_long     = 16'd3000;
	logic [15:0] sh_factory  = 16'd5000;
	logic [15:0] sh_window   = 16'd20000;

	// Result side: ready steps bit by bit through a 32-bit stall word, redrawn once used.
	// A hold-off request drops ready for a long stretch so the pipe fills and the
	// sample channel backs up while the sender keeps offering items.
	initial begin : sink_side
		logic [31:0] stall_pat;
		int unsigned pat_pos;
		res_ch.ready = 1'b0;
		stall_pat    = '1;
		pat_pos      = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
			end
			if (pat_pos == 0) begin
				case (sink_mode)
					0:       stall_pat = '1;
					1:       stall_pat = $urandom | $urandom | $urandom;
					default: stall_pat = $urandom;
				endcase
			end
			res_ch.ready <= stall_pat[pat_pos];
			pat_pos = (pat_pos + 1) % 32;
		end
	end

	// Watchdog: any handshake on any channel restarts the count.
	int unsigned quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchdogLimit) begin
			$display("button_gesture_classifier_unit verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one sample item and return at the edge where it is taken. With gaps on,
	// items go out in bursts of random length separated by idle cycles.
	task automatic send_sample(input logic pressed, input logic [31:0] now);
		int unsigned gap;
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap        = $urandom_range(1, 8);
			smp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left != 0)
			burst_left--;
		smp_ch.valid <= 1'b1;
		smp_ch.data  <= {pressed, now};
		@(posedge clk);
		while (!smp_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	// Hold the button at one level for at least span ms; each step is random up to a
	// third of the span, so the sample count does not grow with the span and long holds stay cheap.
	task automatic hold_level(input logic level, input logic [31:0] span);
		logic [31:0] t0, stride;
		t0     = clock_ms;
		stride = span / 3 + 1;
		do begin
			clock_ms += $urandom_range(1, stride);
			send_sample(level, clock_ms);
		end while (clock_ms - t0 < span);
	endtask

	// Stop offering and wait until every predicted report has been taken. The
	// first edge is waited out so that an item taken just now is counted.
	task automatic await_drain();
		smp_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (reports_due != 0);
	endtask

	task automatic write_reg(input bgc_reg_t idx, input logic [15:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= {idx, value};
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	// Registers change only with the block idle.
	task automatic program_regs(input logic [15:0] db, input logic [15:0] dc,
		input logic [15:0] lp, input logic [15:0] fh, input logic [15:0] rw, input logic cb);
		await_drain();
		write_reg(REG_DEBOUNCE, db);
		write_reg(REG_DOUBLE_CLICK, dc);
		write_reg(REG_LONG_PRESS, lp);
		write_reg(REG_FACTORY_HOLD, fh);
		write_reg(REG_RESET_WINDOW, rw);
		write_reg(REG_CLEAN_BOOT, {15'd0, cb});
		cfg_ch.valid <= 1'b0;
		sh_debounce = db;
		sh_double   = dc;
		sh_long     = lp;
		sh_factory  = fh;
		sh_window   = rw;
	endtask

	// Mostly well-formed gestures with random timing, plus bounces, noise and
	// time jumps. Stops once the given number of items has gone out.
	task automatic run_gestures(input int unsigned budget);
		int unsigned start, kind, reps;
		start = items_sent;
		while (items_sent - start < budget) begin
			kind = $urandom_range(0, 11);
			case (kind)
				0, 1, 2, 3, 4: begin
					// click train; the long one can run into saturation at 15
					reps = (kind == 0) ? $urandom_range(13, 18) : $urandom_range(1, 4);
					repeat (reps) begin
						hold_level(1'b1, $urandom_range(0, sh_long / 2));
						hold_level(1'b0, sh_debounce + $urandom_range(0, sh_double / 2));
					end
					hold_level(1'b0, sh_double + 1);
				end
				5, 6: begin
					// long hold, may also reach the factory hold time
					hold_level(1'b1, sh_long + $urandom_range(0, sh_factory));
					hold_level(1'b0, sh_debounce + $urandom_range(0, sh_double));
				end
				7: begin
					hold_level(1'b1, sh_factory + $urandom_range(0, 50));
					hold_level(1'b0, $urandom_range(0, sh_double));
				end
				8: begin
					// bounce: level changes faster than the debounce time
					repeat (3) begin
						clock_ms += $urandom_range(0, sh_debounce / 2 + 1);
						send_sample($urandom_range(0, 1) == 1, clock_ms);
					end
				end
				9: begin
					// noise: random level at a random time anywhere in the range
					repeat ($urandom_range(1, 3)) begin
						clock_ms = $urandom;
						send_sample($urandom_range(0, 1) == 1, clock_ms);
					end
				end
				10: begin
					// back inside the window so a fresh press can be eligible
					clock_ms = $urandom_range(0, sh_window);
					hold_level(1'b0, sh_debounce + 1);
					hold_level(1'b1, sh_factory + $urandom_range(0, 20));
					hold_level(1'b0, $urandom_range(0, sh_double));
				end
				default: hold_level(1'b0, sh_double + $urandom_range(0, sh_double));
			endcase
		end
	endtask

	initial begin
		smp_ch.valid = 1'b0;
		smp_ch.data  = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset register values, no idling on either side.
		send_sample(1'b1, 32'd0);          // held at start-up: ignored
		send_sample(1'b0, 32'd10);         // first release ends the start-up ignore
		send_sample(1'b1, 32'd20);         // too soon after release time 0: rejected
		send_sample(1'b1, 32'd60);         // accepted while the window is open
		send_sample(1'b1, 32'd5060);       // factory hold reached: armed
		send_sample(1'b0, 32'd5100);       // release while armed: reset confirmed
		send_sample(1'b0, 32'd5200);       // ignore phase again, cleared by release
		send_sample(1'b1, 32'd20000);      // window closes on this very item
		send_sample(1'b1, 32'd23000);      // ineligible press held: long press
		send_sample(1'b0, 32'd23100);      // release after long press counts nothing
		send_sample(1'b1, 32'd23200);
		send_sample(1'b0, 32'd23300);
		send_sample(1'b1, 32'd23400);
		send_sample(1'b0, 32'd23500);
		send_sample(1'b0, 32'd23900);      // gap exactly met: multi click of 2
		send_sample(1'b1, 32'd23960);
		send_sample(1'b0, 32'd24000);
		send_sample(1'b0, 32'd24400);      // single click
		send_sample(1'b1, 32'hFFFF_FF00);
		send_sample(1'b0, 32'hFFFF_FFF0);
		send_sample(1'b1, 32'h0000_0010);  // debounce measured across the wrap
		send_sample(1'b0, 32'hFFFF_FFFF);  // time going back: not yet quiet
		send_sample(1'b0, 32'h0000_0200);  // quiet across the wrap: single click

		// Reset values, coarse timing.
		clock_ms  = 32'h0000_0200;
		gaps_on   = 1'b1;
		sink_mode = 1;
		run_gestures(120);

		// Short times, window open at first. Starts with no idling and one long
		// receiver hold-off while the sender keeps pushing.
		program_regs(16'd3, 16'd30, 16'd80, 16'd120, 16'd600, 1'b1);
		clock_ms     = '0;
		gaps_on      = 1'b0;
		sink_mode    = 0;
		hold_off_req = 1'b1;
		run_gestures(90);
		gaps_on   = 1'b1;
		sink_mode = 2;
		run_gestures(130);

		// Lowest register values in range; the window shuts on the first item, clean boot off.
		program_regs(16'd0, 16'd1, 16'd1, 16'd1, 16'd0, 1'b0);
		sink_mode = 2;
		run_gestures(100);

		// Zero hold and gap times: events on the accepting and releasing items.
		program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd40, 1'b1);
		clock_ms  = '0;
		gaps_on   = 1'b0;
		sink_mode = 1;
		run_gestures(60);

		// Highest values, time running through the wrap.
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		clock_ms  = 32'hFFFF_0000;
		gaps_on   = 1'b1;
		sink_mode = 0;
		run_gestures(150);

		// Random register values.
		program_regs(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(1, 16'hFFFF)),
			16'($urandom_range(1, 16'hFFFF)), 16'($urandom_range(1, 16'hFFFF)),
			16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 1) == 1);
		clock_ms  = '0;
		sink_mode = 1;
		run_gestures(200);

		await_drain();
		repeat (SettleCycles) @(posedge clk);
		if (fail_count == 0)
			$display("button_gesture_classifier_unit verification clean");
		else
			$display("button_gesture_classifier_unit verification failed");
		$finish;
	end

endmodule
